### src/sxyz_pkg.sv
// ----------------------------------------------------------------------------
// sxyz_pkg: shared constants for the sRGB to CIE XYZ converter
// Holds the fixed-point formats, the matrix coefficients, the reciprocal
// constant used by the divider, and the linearization table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package sxyz_pkg;

  localparam int unsigned FRAC_BITS = 10;
  localparam int unsigned LIN_W     = 31;   // Q1.30, up to 1.0 inclusive
  localparam int unsigned COEF_W    = 14;
  localparam int unsigned PROD_W    = LIN_W + COEF_W;
  localparam int unsigned SUM_W     = PROD_W + 2;
  localparam int unsigned OUT_W     = 17;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned NUM_CH    = 3;

  // Rounding and scaling: out = floor((S + HALF) / (100 << SCALE_SH)).
  localparam int unsigned SCALE_SH  = 30 - FRAC_BITS;
  localparam logic [63:0] HALF      = 64'd50 << SCALE_SH;

  // Division of a 31-bit quotient by 100 as a multiply by ceil(2^38 / 100).
  localparam int unsigned QUO_W     = 31;
  localparam int unsigned RECIP_W   = 32;
  localparam int unsigned RECIP_SH  = 38;
  localparam logic [RECIP_W-1:0] RECIP = 32'd2748779070;
  localparam logic [OUT_W-1:0]   OUT_MAX = {OUT_W{1'b1}};

  typedef logic [COEF_W-1:0] coef_t;
  typedef coef_t [NUM_CH-1:0] coef_col_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef prod_t [NUM_CH-1:0] prod_vec_t;

  // Coefficient columns: entry [lane][row].
  localparam coef_col_t COEF_COL [NUM_CH] = '{
    '{14'd193,  14'd2126, 14'd4124},
    '{14'd1192, 14'd7152, 14'd3576},
    '{14'd9505, 14'd722,  14'd1805}
  };

  typedef logic [LIN_W-1:0] lin_rom_t [0:255];

  function automatic longint unsigned fifth_pow(input longint unsigned v);
    longint unsigned sq;
    longint unsigned qu;
    sq = (v * v) >> 30;
    qu = (sq * sq) >> 30;
    return (qu * v) >> 30;
  endfunction

  // Built at elaboration; the table is a constant ROM in hardware.
  function automatic lin_rom_t build_lin_rom();
    lin_rom_t         rom;
    longint unsigned  c;
    longint unsigned  x;
    longint unsigned  t;
    longint unsigned  y;
    longint unsigned  cand;
    longint unsigned  one;
    one = 64'd1 << 30;
    for (int i = 0; i < 256; i++) begin
      c = longint'(i);
      if (c * 100000 <= 1031475) begin
        rom[i] = LIN_W'(((c * 10) * one + 16473) / 32946);
      end else begin
        x = ((1000 * c + 14025) * one + 134512) / 269025;
        t = (x * x + (one >> 1)) >> 30;
        y = 0;
        for (int b = 30; b >= 0; b--) begin
          cand = y + (64'd1 << b);
          if (cand <= one && fifth_pow(cand) <= t) begin
            y = cand;
          end
        end
        rom[i] = LIN_W'((t * y + (one >> 1)) >> 30);
      end
    end
    return rom;
  endfunction

  localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage

`default_nettype wire

### src/sxyz_lane.sv
// ----------------------------------------------------------------------------
// sxyz_lane: one color channel lane
// Looks up the linear value of one channel and weights it by its matrix column.
// ----------------------------------------------------------------------------
`default_nettype none

module sxyz_lane (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [sxyz_pkg::CHAN_W-1:0]  chan_i,
  input  wire sxyz_pkg::coef_col_t          coef_i,
  output sxyz_pkg::prod_vec_t               prod_o
);

  logic [sxyz_pkg::LIN_W-1:0] lin_q;
  sxyz_pkg::prod_vec_t        prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lin_q <= sxyz_pkg::LIN_ROM[chan_i];
      for (int r = 0; r < sxyz_pkg::NUM_CH; r++) begin
        prod_q[r] <= sxyz_pkg::PROD_W'(lin_q) * sxyz_pkg::PROD_W'(coef_i[r]);
      end
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

### src/sxyz_merge.sv
// ----------------------------------------------------------------------------
// sxyz_merge: row merge for one output component
// Adds the three lane products, rounds, divides by the scale and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module sxyz_merge (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire sxyz_pkg::prod_t             p0_i,
  input  wire sxyz_pkg::prod_t             p1_i,
  input  wire sxyz_pkg::prod_t             p2_i,
  output logic [sxyz_pkg::OUT_W-1:0]       value_o
);

  localparam int unsigned MUL_W = sxyz_pkg::QUO_W + sxyz_pkg::RECIP_W;

  logic [63:0]                   sum_d;
  logic [sxyz_pkg::QUO_W-1:0]    quo_q;
  logic [MUL_W-1:0]              mul_q;
  logic [MUL_W-1:0]              div_d;
  logic [sxyz_pkg::OUT_W-1:0]    val_q;

  always_comb begin
    sum_d = 64'(p0_i) + 64'(p1_i) + 64'(p2_i) + sxyz_pkg::HALF;
    div_d = mul_q >> sxyz_pkg::RECIP_SH;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= sxyz_pkg::QUO_W'(sum_d >> sxyz_pkg::SCALE_SH);
      mul_q <= MUL_W'(quo_q) * MUL_W'(sxyz_pkg::RECIP);
      if (div_d > MUL_W'(sxyz_pkg::OUT_MAX)) begin
        val_q <= sxyz_pkg::OUT_MAX;
      end else begin
        val_q <= div_d[sxyz_pkg::OUT_W-1:0];
      end
    end
  end

  assign value_o = val_q;

endmodule

`default_nettype wire

### src/srgb_to_xyz_core.sv
// ----------------------------------------------------------------------------
// srgb_to_xyz_core: sRGB pixel to CIE XYZ (D65) converter
// Three channel lanes linearize red, green and blue through a constant table
// and weight them by the matrix; three merge units form X, Y and Z.
// ----------------------------------------------------------------------------
//  Channel  Dir  Bits  Fields (lowest bit first)
//  s_axis   in   24    red[7:0], green[15:8], blue[23:16]
//  m_axis   out  56    x_value[16:0], y_value[33:17], z_value[50:34], zero pad
//
// A pixel passes these stages in order, and one beat is taken every cycle
// unless the output stalls: table read, lane products, row sum and rounding
// shift, reciprocal multiply, then the saturating output register.
// Reset clears only the stage valid bits; data registers are not reset.
// When the output beat is held by the sink, the whole pipeline freezes and
// s_axis_tready_o drops; while the output stage is empty the pipeline keeps
// moving even if the sink holds off.
// ----------------------------------------------------------------------------
`default_nettype none

module srgb_to_xyz_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // red, green, blue
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [55:0]      m_axis_tdata_o    // x_value, y_value, z_value, pad
);

  localparam int unsigned DEPTH = 5;

  logic [DEPTH-1:0] vld_q;
  logic [DEPTH-1:0] vld_d;
  logic             en;
  sxyz_pkg::prod_vec_t prod [sxyz_pkg::NUM_CH];
  logic [sxyz_pkg::OUT_W-1:0] xyz [sxyz_pkg::NUM_CH];

  // The pipeline moves whenever the output stage is empty or being drained.
  assign en              = !vld_q[DEPTH-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[DEPTH-1];

  always_comb begin
    vld_d = {vld_q[DEPTH-2:0], s_axis_tvalid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // One lane per color channel.
  for (genvar l = 0; l < sxyz_pkg::NUM_CH; l++) begin : g_lane
    sxyz_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .chan_i (s_axis_tdata_i[l*sxyz_pkg::CHAN_W +: sxyz_pkg::CHAN_W]),
      .coef_i (sxyz_pkg::COEF_COL[l]),
      .prod_o (prod[l])
    );
  end

  // One merge unit per output component, combining the three lanes.
  for (genvar r = 0; r < sxyz_pkg::NUM_CH; r++) begin : g_row
    sxyz_merge u_merge (
      .clk_i   (clk_i),
      .en_i    (en),
      .p0_i    (prod[0][r]),
      .p1_i    (prod[1][r]),
      .p2_i    (prod[2][r]),
      .value_o (xyz[r])
    );
  end

  assign m_axis_tdata_o = {5'd0, xyz[2], xyz[1], xyz[0]};

endmodule

`default_nettype wire

### test/tb_srgb_to_xyz_core.sv
// ----------------------------------------------------------------------------
// tb_srgb_to_xyz_core: stream test of the sRGB to CIE XYZ converter
// Pixels go in on s_axis with random gaps, and the sink stalls at random,
// once for a long stretch. Every output beat is checked against a predicted
// X, Y and Z worked out from the linearization rule and the fixed matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_srgb_to_xyz_core;

  typedef struct packed {
    logic [16:0] x_value;
    logic [16:0] y_value;
    logic [16:0] z_value;
  } xyz_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;   // red, green, blue
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [55:0] m_axis_tdata_o;   // x_value, y_value, z_value, pad

  xyz_t        xyz_queue[$];
  longint unsigned lin_tab[256];
  int          mismatches;
  bit          sink_idle_on;
  bit          src_idle_on;
  bit          hold_sink;

  srgb_to_xyz_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("srgb_to_xyz_core: mismatch");
    $finish;
  end

  function automatic longint unsigned pow5_q30(longint unsigned v);
    longint unsigned sq;
    longint unsigned qu;
    sq = (v * v) >> 30;
    qu = (sq * sq) >> 30;
    return (qu * v) >> 30;
  endfunction

  // Linear light of one code in Q1.30.
  function automatic longint unsigned decode_gamma(longint unsigned c);
    longint unsigned one;
    longint unsigned x;
    longint unsigned t;
    longint unsigned y;
    longint unsigned cand;
    one = 64'd1 << 30;
    if (c * 100000 <= 1031475) return ((c * 10) * one + 16473) / 32946;
    x = ((1000 * c + 14025) * one + 134512) / 269025;
    t = (x * x + (one >> 1)) >> 30;
    y = 0;
    for (int b = 30; b >= 0; b--) begin
      cand = y + (64'd1 << b);
      if (cand <= one && pow5_q30(cand) <= t) y = cand;
    end
    return (t * y + (one >> 1)) >> 30;
  endfunction

  function automatic logic [16:0] scale_row(longint unsigned s);
    longint unsigned sh;
    longint unsigned v;
    sh = 30 - sxyz_pkg::FRAC_BITS;
    v = (s + (64'd50 << sh)) / (64'd100 << sh);
    if (v > 131071) v = 131071;
    return v[16:0];
  endfunction

  function automatic xyz_t convert_pixel(logic [23:0] px);
    longint unsigned r;
    longint unsigned g;
    longint unsigned b;
    xyz_t o;
    r = lin_tab[px[7:0]];
    g = lin_tab[px[15:8]];
    b = lin_tab[px[23:16]];
    o.x_value = scale_row(r * 4124 + g * 3576 + b * 1805);
    o.y_value = scale_row(r * 2126 + g * 7152 + b * 722);
    o.z_value = scale_row(r * 193 + g * 1192 + b * 9505);
    return o;
  endfunction

  // Sends one pixel beat; valid stays up across back-to-back beats and is
  // dropped only in an idle cycle or after the last beat.
  task automatic send_pixel(logic [23:0] px);
    while (src_idle_on && $urandom_range(99) < 8) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= px;
    xyz_queue.push_back(convert_pixel(px));
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Sink: random stalls, or a long hold when asked.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= !hold_sink && !(sink_idle_on && $urandom_range(99) < 8);
    end
  end

  // Checker: compare each beat against the oldest prediction.
  always @(posedge clk_i) begin
    xyz_t got;
    xyz_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.x_value = m_axis_tdata_o[16:0];
      got.y_value = m_axis_tdata_o[33:17];
      got.z_value = m_axis_tdata_o[50:34];
      if (xyz_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", m_axis_tdata_o);
      end else begin
        want = xyz_queue.pop_front();
        if (got != want || m_axis_tdata_o[55:51] != 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("expected X %0d Y %0d Z %0d, got X %0d Y %0d Z %0d pad %h",
                     want.x_value, want.y_value, want.z_value,
                     got.x_value, got.y_value, got.z_value, m_axis_tdata_o[55:51]);
        end
      end
    end
  end

  task automatic test_extremes();
    logic [7:0] codes[8] = '{8'd0, 8'd255, 8'd10, 8'd11, 8'd1, 8'd128, 8'd85, 8'd170};
    foreach (codes[i]) send_pixel({codes[i], codes[i], codes[i]});
    send_pixel(24'h0000FF); send_pixel(24'h00FF00); send_pixel(24'hFF0000);
    send_pixel(24'h0B0A0B); send_pixel(24'hFFFF00); send_pixel(24'h00FFFF);
    send_pixel(24'hAA55AA); send_pixel(24'h55AA55);
  endtask

  task automatic test_random(int n);
    repeat (n) send_pixel(24'($urandom));
  endtask

  // Sink holds off for a long stretch while pixels keep coming.
  task automatic test_backpressure();
    fork
      begin
        hold_sink = 1'b1;
        repeat (60) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      test_random(30);
    join
  endtask

  task automatic test_no_idle(int n);
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    test_random(n);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  initial begin
    mismatches = 0;
    hold_sink = 1'b0;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    for (int i = 0; i < 256; i++) lin_tab[i] = decode_gamma(i);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_extremes();
    test_random(300);
    test_backpressure();
    test_no_idle(150);
    test_random(150);
    s_axis_tvalid_i <= 1'b0;
    while (xyz_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("srgb_to_xyz_core: match");
    end else begin
      $display("srgb_to_xyz_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
src/sxyz_pkg.sv
src/sxyz_lane.sv
src/sxyz_merge.sv
src/srgb_to_xyz_core.sv
test/tb_srgb_to_xyz_core.sv
